### hdl/pcsp_pkg.sv
// Shared types and constants for the planar code stream parser.
// Depends on nothing; used by every module of the block.
package pcsp_pkg;

    localparam logic [7:0] HEADER_RESET = 8'd15;

    typedef enum logic [2:0] {
        PH_COUNT,
        PH_WCOUNT_LO,
        PH_WCOUNT_HI,
        PH_LIST_LO,
        PH_LIST_HI
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NEIGHBOUR = 2'd0,
        KIND_LIST_END  = 2'd1,
        KIND_START     = 2'd2,
        KIND_TRUNC     = 2'd3
    } kind_t;

    typedef struct packed {
        logic       eod;
        logic [7:0] data;
    } token_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] vertex_index;
        logic [15:0] item_value;
        logic        wide;
        logic        last;
    } result_t;

endpackage

### hdl/planar_code_stream_parser_top.sv
// Top level of the planar code stream parser: front end, token queue, back end.
// Path: a byte goes to the token queue, then its result word, if any, to the output queue.
// Throughput: one byte per cycle while full is low; each side holds a two-word queue.
// Reset: asynchronous, active low; header length 15, parser waits in the header.
// Depends on pcsp_pkg, pcsp_front and pcsp_back.
module planar_code_stream_parser_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        end_of_data,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  kind,
    output logic [15:0] vertex_index,
    output logic [15:0] item_value,
    output logic        wide_numbers,
    output logic        graph_last
);

    logic              tok_valid, tok_take;
    pcsp_pkg::token_t  tok;
    pcsp_pkg::result_t res;

    pcsp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .push        (push),
        .full        (full),
        .data_byte   (data_byte),
        .end_of_data (end_of_data),
        .tok_valid   (tok_valid),
        .tok         (tok),
        .tok_take    (tok_take)
    );

    pcsp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (tok_valid),
        .tok       (tok),
        .tok_take  (tok_take),
        .empty     (empty),
        .pop       (pop),
        .res       (res)
    );

    assign kind         = res.kind;
    assign vertex_index = res.vertex_index;
    assign item_value   = res.item_value;
    assign wide_numbers = res.wide;
    assign graph_last   = res.last;

endmodule

### hdl/pcsp_front.sv
// Front end: accepts stream bytes, skips the header once, queues tokens.
// Depends on pcsp_pkg.
module pcsp_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_data,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        data_byte,
    input  logic              end_of_data,
    output logic              tok_valid,
    output pcsp_pkg::token_t  tok,
    input  logic              tok_take
);

    logic             header_active_reg, header_active_next;
    logic [7:0]       header_left_reg, header_left_next;
    pcsp_pkg::token_t q_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg, count_next;
    logic             in_fire, fwd;

    assign full      = (count_reg == 2'd2);
    assign in_fire   = push & ~full;
    assign tok_valid = (count_reg != 2'd0);
    assign tok       = q_reg[rd_ptr_reg];

    always_comb
    begin
        header_active_next = header_active_reg;
        header_left_next   = header_left_reg;
        fwd                = 1'b0;
        if (cfg_we && header_active_reg)
        begin
            header_left_next = cfg_data;
        end
        if (in_fire)
        begin
            if (!header_active_reg)
            begin
                fwd = 1'b1;
            end
            else if (!end_of_data)
            begin
                if (header_left_reg != 8'd0)
                begin
                    header_left_next = header_left_reg - 8'd1;
                end
                else
                begin
                    header_active_next = 1'b0;
                    fwd                = 1'b1;
                end
            end
        end
        count_next = count_reg + {1'b0, fwd} - {1'b0, tok_take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_active_reg <= 1'b1;
            header_left_reg   <= pcsp_pkg::HEADER_RESET;
            wr_ptr_reg        <= 1'b0;
            rd_ptr_reg        <= 1'b0;
            count_reg         <= 2'd0;
        end
        else
        begin
            header_active_reg <= header_active_next;
            header_left_reg   <= header_left_next;
            count_reg         <= count_next;
            if (fwd)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (tok_take)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fwd)
        begin
            q_reg[wr_ptr_reg] <= '{eod: end_of_data, data: data_byte};
        end
    end

endmodule

### hdl/pcsp_back.sv
// Back end: graph parser state machine and result word queue.
// Depends on pcsp_pkg; fed by pcsp_front.
module pcsp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tok_valid,
    input  pcsp_pkg::token_t  tok,
    output logic              tok_take,
    output logic              empty,
    input  logic              pop,
    output pcsp_pkg::result_t res
);

    pcsp_pkg::phase_t  phase_reg, phase_next;
    logic              wide_reg, wide_next;
    logic [7:0]        hold_reg, hold_next;
    logic [15:0]       total_reg, total_next;
    logic [15:0]       cur_reg, cur_next;
    pcsp_pkg::result_t q_reg [2];
    logic              wr_ptr_reg, rd_ptr_reg;
    logic [1:0]        count_reg;
    logic              emit, out_pop;
    pcsp_pkg::result_t emit_res;
    logic [15:0]       number;
    logic [15:0]       wcount;
    logic              list_sel;
    logic              list_last;

    assign tok_take  = tok_valid & (count_reg != 2'd2);
    assign empty     = (count_reg == 2'd0);
    assign out_pop   = pop & ~empty;
    assign res       = q_reg[rd_ptr_reg];
    assign wcount    = {tok.data, hold_reg};
    assign number    = (phase_reg == pcsp_pkg::PH_LIST_HI) ? wcount : {8'd0, tok.data};
    assign list_sel  = (phase_reg == pcsp_pkg::PH_LIST_HI)
                    || ((phase_reg == pcsp_pkg::PH_LIST_LO) && !wide_reg);
    assign list_last = ({1'b0, cur_reg} + 17'd1) == {1'b0, total_reg};

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (tok_take)
        begin
            if (tok.eod)
            begin
                phase_next = pcsp_pkg::PH_COUNT;
            end
            else
            begin
                unique case (phase_reg)
                    pcsp_pkg::PH_COUNT:
                        phase_next = (tok.data == 8'd0) ? pcsp_pkg::PH_WCOUNT_LO
                                                        : pcsp_pkg::PH_LIST_LO;
                    pcsp_pkg::PH_WCOUNT_LO:
                        phase_next = pcsp_pkg::PH_WCOUNT_HI;
                    pcsp_pkg::PH_WCOUNT_HI:
                        phase_next = (wcount == 16'd0) ? pcsp_pkg::PH_COUNT
                                                       : pcsp_pkg::PH_LIST_LO;
                    pcsp_pkg::PH_LIST_LO,
                    pcsp_pkg::PH_LIST_HI:
                    begin
                        if (!list_sel)
                            phase_next = pcsp_pkg::PH_LIST_HI;
                        else if (number == 16'd0 && list_last)
                            phase_next = pcsp_pkg::PH_COUNT;
                        else
                            phase_next = pcsp_pkg::PH_LIST_LO;
                    end
                    default:
                        phase_next = pcsp_pkg::PH_COUNT;
                endcase
            end
        end
    end

    // datapath and result word
    always_comb
    begin
        wide_next  = wide_reg;
        hold_next  = hold_reg;
        total_next = total_reg;
        cur_next   = cur_reg;
        emit       = 1'b0;
        emit_res   = '{kind: pcsp_pkg::KIND_NEIGHBOUR, vertex_index: cur_reg,
                       item_value: 16'd0, wide: wide_reg, last: 1'b0};
        if (tok_take)
        begin
            if (tok.eod)
            begin
                if (phase_reg != pcsp_pkg::PH_COUNT)
                begin
                    emit                = 1'b1;
                    emit_res.kind       = pcsp_pkg::KIND_TRUNC;
                    emit_res.item_value = total_reg;
                    emit_res.last       = 1'b1;
                    wide_next           = 1'b0;
                    total_next          = 16'd0;
                    cur_next            = 16'd0;
                end
            end
            else
            begin
                unique case (phase_reg)
                    pcsp_pkg::PH_COUNT:
                    begin
                        total_next = {8'd0, tok.data};
                        cur_next   = 16'd0;
                        if (tok.data == 8'd0)
                        begin
                            wide_next = 1'b1;
                        end
                        else
                        begin
                            wide_next             = 1'b0;
                            emit                  = 1'b1;
                            emit_res.kind         = pcsp_pkg::KIND_START;
                            emit_res.vertex_index = 16'd0;
                            emit_res.item_value   = {8'd0, tok.data};
                            emit_res.wide         = 1'b0;
                        end
                    end
                    pcsp_pkg::PH_WCOUNT_LO:
                        hold_next = tok.data;
                    pcsp_pkg::PH_WCOUNT_HI:
                    begin
                        total_next = wcount;
                        cur_next   = 16'd0;
                        if (wcount == 16'd0)
                        begin
                            wide_next = 1'b0;
                        end
                        else
                        begin
                            emit                  = 1'b1;
                            emit_res.kind         = pcsp_pkg::KIND_START;
                            emit_res.vertex_index = 16'd0;
                            emit_res.item_value   = wcount;
                        end
                    end
                    pcsp_pkg::PH_LIST_LO,
                    pcsp_pkg::PH_LIST_HI:
                    begin
                        if (!list_sel)
                        begin
                            hold_next = tok.data;
                        end
                        else if (number != 16'd0)
                        begin
                            emit                = 1'b1;
                            emit_res.item_value = number - 16'd1;
                        end
                        else
                        begin
                            emit          = 1'b1;
                            emit_res.kind = pcsp_pkg::KIND_LIST_END;
                            if (list_last)
                            begin
                                emit_res.last = 1'b1;
                                wide_next     = 1'b0;
                                total_next    = 16'd0;
                                cur_next      = 16'd0;
                            end
                            else
                            begin
                                cur_next = cur_reg + 16'd1;
                            end
                        end
                    end
                    default:
                    begin
                        wide_next  = 1'b0;
                        total_next = 16'd0;
                        cur_next   = 16'd0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= pcsp_pkg::PH_COUNT;
            wide_reg   <= 1'b0;
            hold_reg   <= 8'd0;
            total_reg  <= 16'd0;
            cur_reg    <= 16'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            wide_reg  <= wide_next;
            hold_reg  <= hold_next;
            total_reg <= total_next;
            cur_reg   <= cur_next;
            count_reg <= count_reg + {1'b0, emit} - {1'b0, out_pop};
            if (emit)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (out_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            q_reg[wr_ptr_reg] <= emit_res;
        end
    end

endmodule

### tb/sv/pcsp_stream_checker.sv
// Result checker for the planar code stream parser: tracks the parse state
// from accepted bytes and header-length writes, and compares popped words in order.
// Depends on pcsp_pkg.
module pcsp_stream_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_data,
    input  logic        push,
    input  logic        full,
    input  logic [7:0]  data_byte,
    input  logic        end_of_data,
    input  logic        empty,
    input  logic        pop,
    input  logic [1:0]  kind,
    input  logic [15:0] vertex_index,
    input  logic [15:0] item_value,
    input  logic        wide_numbers,
    input  logic        graph_last,
    output int          fail_count,
    output int          waiting
);

    logic [7:0]         hdr_len;
    logic [7:0]         hdr_left;
    logic               in_hdr;
    pcsp_pkg::phase_t   phase;
    logic               wide;
    logic [7:0]         lo_hold;
    logic [15:0]        vtotal;
    logic [15:0]        vcur;
    pcsp_pkg::result_t  decoded_q[$];
    int                 errors = 0;

    assign fail_count = errors;

    function automatic void return_to_count();
        phase  = pcsp_pkg::PH_COUNT;
        wide   = 1'b0;
        vtotal = '0;
        vcur   = '0;
    endfunction

    function automatic void expect_word(pcsp_pkg::kind_t k, logic [15:0] vi,
                                        logic [15:0] val, logic lst);
        pcsp_pkg::result_t r;
        r.kind         = k;
        r.vertex_index = vi;
        r.item_value   = val;
        r.wide         = wide;
        r.last         = lst;
        decoded_q = {decoded_q, r};
    endfunction

    function automatic void open_graph(logic [15:0] n);
        if (n == 16'd0)
        begin
            return_to_count();
        end
        else
        begin
            vtotal = n;
            vcur   = '0;
            phase  = pcsp_pkg::PH_LIST_LO;
            expect_word(pcsp_pkg::KIND_START, 16'd0, n, 1'b0);
        end
    endfunction

    function automatic void take_number(logic [15:0] v);
        if (v != 16'd0)
        begin
            phase = pcsp_pkg::PH_LIST_LO;
            expect_word(pcsp_pkg::KIND_NEIGHBOUR, vcur, v - 16'd1, 1'b0);
        end
        else if ({1'b0, vcur} + 17'd1 == {1'b0, vtotal})
        begin
            expect_word(pcsp_pkg::KIND_LIST_END, vcur, 16'd0, 1'b1);
            return_to_count();
        end
        else
        begin
            expect_word(pcsp_pkg::KIND_LIST_END, vcur, 16'd0, 1'b0);
            vcur  = vcur + 16'd1;
            phase = pcsp_pkg::PH_LIST_LO;
        end
    endfunction

    function automatic void take_count(logic [7:0] b);
        if (b == 8'd0)
        begin
            wide   = 1'b1;
            vtotal = '0;
            vcur   = '0;
            phase  = pcsp_pkg::PH_WCOUNT_LO;
        end
        else
        begin
            wide = 1'b0;
            open_graph({8'd0, b});
        end
    endfunction

    function automatic void take_token(logic [7:0] b, logic eod);
        if (eod)
        begin
            if (!in_hdr && phase != pcsp_pkg::PH_COUNT)
            begin
                expect_word(pcsp_pkg::KIND_TRUNC, vcur, vtotal, 1'b1);
                return_to_count();
            end
        end
        else if (in_hdr)
        begin
            if (hdr_left != 8'd0)
            begin
                hdr_left = hdr_left - 8'd1;
            end
            else
            begin
                in_hdr = 1'b0;
                take_count(b);
            end
        end
        else
        begin
            case (phase)
                pcsp_pkg::PH_COUNT:     take_count(b);
                pcsp_pkg::PH_WCOUNT_LO:
                begin
                    lo_hold = b;
                    phase   = pcsp_pkg::PH_WCOUNT_HI;
                end
                pcsp_pkg::PH_WCOUNT_HI: open_graph({b, lo_hold});
                pcsp_pkg::PH_LIST_LO:
                begin
                    if (wide)
                    begin
                        lo_hold = b;
                        phase   = pcsp_pkg::PH_LIST_HI;
                    end
                    else
                    begin
                        take_number({8'd0, b});
                    end
                end
                pcsp_pkg::PH_LIST_HI:   take_number({b, lo_hold});
                default:                return_to_count();
            endcase
        end
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    task automatic check_word(pcsp_pkg::result_t want);
        if (kind != want.kind)
            report_mismatch($sformatf("kind got %0d want %0d", kind, want.kind));
        if (vertex_index != want.vertex_index)
            report_mismatch($sformatf("vertex_index got %0d want %0d",
                                      vertex_index, want.vertex_index));
        if (item_value != want.item_value)
            report_mismatch($sformatf("item_value got %0d want %0d",
                                      item_value, want.item_value));
        if (wide_numbers != want.wide)
            report_mismatch($sformatf("wide_numbers got %0d want %0d",
                                      wide_numbers, want.wide));
        if (graph_last != want.last)
            report_mismatch($sformatf("graph_last got %0d want %0d",
                                      graph_last, want.last));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pcsp_pkg::result_t want;
        if (!rst_n)
        begin
            hdr_len  = pcsp_pkg::HEADER_RESET;
            hdr_left = pcsp_pkg::HEADER_RESET;
            in_hdr   = 1'b1;
            lo_hold  = '0;
            return_to_count();
            decoded_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                hdr_len = cfg_data;
                if (in_hdr)
                    hdr_left = hdr_len;
            end
            if (push && !full)
                take_token(data_byte, end_of_data);
            if (pop && !empty)
            begin
                if (decoded_q.size() == 0)
                begin
                    report_mismatch($sformatf("word kind %0d with none expected", kind));
                end
                else
                begin
                    want = decoded_q.pop_front();
                    check_word(want);
                end
            end
        end
        waiting <= decoded_q.size();
    end

endmodule

### tb/sv/tb.sv
// Testbench top for the planar code stream parser: clock, reset, byte stream
// stimulus, result draining and the verdict.
// Depends on pcsp_pkg, planar_code_stream_parser_top and pcsp_stream_checker.
module tb;

    localparam int LIMIT       = 200000;
    localparam int HOLD_CYCLES = 200;
    localparam int SETTLE      = 8;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_we      = 1'b0;
    logic [7:0]  cfg_data    = 8'd0;
    logic        push        = 1'b0;
    logic [7:0]  data_byte   = 8'd0;
    logic        end_of_data = 1'b0;
    logic        pop         = 1'b0;
    logic        full;
    logic        empty;
    logic [1:0]  kind;
    logic [15:0] vertex_index;
    logic [15:0] item_value;
    logic        wide_numbers;
    logic        graph_last;

    int                fail_count;
    int                waiting;
    int                send_idle   = 0;
    int                pop_stall   = 0;
    logic              stall_req   = 1'b0;
    logic              stall_done  = 1'b0;
    int                cycle_count = 0;
    pcsp_pkg::token_t  stream_q[$];

    planar_code_stream_parser_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .data_byte    (data_byte),
        .end_of_data  (end_of_data),
        .empty        (empty),
        .pop          (pop),
        .kind         (kind),
        .vertex_index (vertex_index),
        .item_value   (item_value),
        .wide_numbers (wide_numbers),
        .graph_last   (graph_last)
    );

    pcsp_stream_checker i_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .data_byte    (data_byte),
        .end_of_data  (end_of_data),
        .empty        (empty),
        .pop          (pop),
        .kind         (kind),
        .vertex_index (vertex_index),
        .item_value   (item_value),
        .wide_numbers (wide_numbers),
        .graph_last   (graph_last),
        .fail_count   (fail_count),
        .waiting      (waiting)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb NOT OK");
        $finish;
    end

    // hold pop low for a long stretch once, so the input side backs up
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (stall_req && !stall_done)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                stall_done <= 1'b1;
            end
            pop <= ($urandom_range(0, 99) >= pop_stall);
        end
    end

    function automatic void put_byte(logic [7:0] b);
        pcsp_pkg::token_t t;
        t.eod    = 1'b0;
        t.data   = b;
        stream_q = {stream_q, t};
    endfunction

    function automatic void put_eod();
        pcsp_pkg::token_t t;
        t.eod    = 1'b1;
        t.data   = 8'($urandom_range(0, 255));
        stream_q = {stream_q, t};
    endfunction

    function automatic void put_num(logic [15:0] v, bit w);
        put_byte(v[7:0]);
        if (w)
            put_byte(v[15:8]);
    endfunction

    function automatic void put_graph(bit trunc);
        bit w;
        int n;
        int lists;
        int start;
        int cut;
        start = stream_q.size();
        w = ($urandom_range(0, 3) == 0);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
        if (trunc && $urandom_range(0, 1) == 1)
            n = w ? $urandom_range(256, 65535) : $urandom_range(13, 255);
        lists = (n > 12) ? $urandom_range(1, 3) : n;
        if (w)
        begin
            put_byte(8'd0);
            put_num(16'(n), 1'b1);
        end
        else
        begin
            put_byte(8'(n));
        end
        repeat (lists)
        begin
            repeat ($urandom_range(0, 3))
                put_num(w ? 16'($urandom_range(1, 65535)) : 16'($urandom_range(1, 255)), w);
            put_num(16'd0, w);
        end
        if (trunc)
        begin
            cut = $urandom_range(1, stream_q.size() - start - 1);
            stream_q = stream_q[0 : start + cut - 1];
            put_eod();
        end
    endfunction

    task automatic send_word(pcsp_pkg::token_t w);
        while ($urandom_range(0, 99) < send_idle)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push        <= 1'b1;
        data_byte   <= w.data;
        end_of_data <= w.eod;
        @(posedge clk);
        while (full) @(posedge clk);
    endtask

    task automatic flush_stream();
        while (stream_q.size() != 0)
            send_word(stream_q.pop_front());
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (waiting != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_header_len(logic [7:0] v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic random_run(int nbytes);
        int sent;
        int pick;
        sent = 0;
        while (sent < nbytes)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                put_graph(1'b0);
            end
            else if (pick < 82)
            begin
                put_graph(1'b1);
            end
            else if (pick < 88)
            begin
                put_byte(8'd0);
                put_byte(8'd0);
                put_byte(8'd0);
            end
            else if (pick < 93)
            begin
                put_eod();
            end
            else
            begin
                repeat ($urandom_range(1, 5)) put_byte(8'($urandom_range(0, 255)));
                put_eod();
            end
            sent += stream_q.size();
            flush_stream();
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // skip part of the reset-length header, then reload it: longest, then none
        put_byte(8'h00);
        put_eod();
        put_byte(8'hFF);
        flush_stream();
        wait_drained();
        write_header_len(8'hFF);
        put_byte(8'h5A);
        put_byte(8'hA5);
        flush_stream();
        wait_drained();
        write_header_len(8'h00);

        put_byte(8'd1);
        put_byte(8'd255);
        put_byte(8'd1);
        put_byte(8'd0);
        put_byte(8'd2);
        put_byte(8'd0);
        put_byte(8'd128);
        put_byte(8'd0);
        put_byte(8'd0);
        put_num(16'd2, 1'b1);
        put_num(16'hFFFF, 1'b1);
        put_num(16'd0, 1'b1);
        put_num(16'd0, 1'b1);
        put_byte(8'd0);
        put_num(16'd0, 1'b1);
        put_eod();
        put_byte(8'd0);
        put_eod();
        put_byte(8'd255);
        put_byte(8'd7);
        put_eod();
        put_byte(8'd0);
        put_num(16'hFFFF, 1'b1);
        put_num(16'd1, 1'b1);
        put_eod();
        flush_stream();
        wait_drained();

        stall_req <= 1'b1;
        random_run(100);
        wait_drained();
        write_header_len(8'($urandom_range(1, 254)));

        send_idle <= 88;
        random_run(50);
        wait_drained();
        random_run(50);
        wait_drained();
        write_header_len(8'hFF);

        send_idle <= 0;
        pop_stall <= 88;
        random_run(100);
        wait_drained();
        write_header_len(8'h00);

        send_idle <= 33;
        pop_stall <= 33;
        random_run(100);
        wait_drained();

        if (fail_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
